### rtl/i2cm_pkg.sv
// i2cm_pkg: types and constants for the I2C master byte engine.
// Request, response and sequencer state structs, opcodes, unit counts.
// No dependencies.
package i2cm_pkg;

    typedef enum logic [1:0]
    {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [5:0]  START_UNITS      = 6'd3;
    localparam logic [5:0]  STOP_UNITS       = 6'd3;
    localparam logic [5:0]  WRITE_UNITS      = 6'd36;
    localparam logic [5:0]  READ_UNITS       = 6'd29;
    localparam logic [5:0]  WRITE_BIT_UNITS  = 6'd32;
    localparam logic [5:0]  WRITE_ACK_SAMPLE = 6'd35;
    localparam logic [5:0]  WRITE_ACK_FALL   = 6'd34;
    localparam logic [5:0]  READ_BIT_UNITS   = 6'd24;
    localparam logic [5:0]  READ_ACK_FALL    = 6'd26;
    localparam logic [5:0]  READ_ACK_END     = 6'd28;
    localparam logic [15:0] UNIT_TICKS_RESET = 16'd250;

    typedef struct packed
    {
        logic       cmd_valid;
        op_t        opcode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } req_t;

    typedef struct packed
    {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack;
        logic       rejected;
    } rsp_t;

    typedef struct packed
    {
        op_t         active_op;
        logic        busy;
        logic [5:0]  unit_index;
        logic [15:0] tick_count;
        logic [7:0]  shift_byte;
        logic [7:0]  rx_byte;
        logic        nack;
        logic        scl_drive;
        logic        sda_drive;
        logic        ack_choice;
    } seq_state_t;

    function automatic logic [5:0] op_units(input op_t op);
        logic [5:0] n;
        case (op)
            OP_START: n = START_UNITS;
            OP_STOP:  n = STOP_UNITS;
            OP_WRITE: n = WRITE_UNITS;
            default:  n = READ_UNITS;
        endcase
        return n;
    endfunction

endpackage

### rtl/i2c_master_byte_engine.sv
// i2c_master_byte_engine: top level, tick handshake, unit length register,
// sequencer state and response register. Depends on i2cm_pkg, i2cm_step.
//
//  channel     dir  handshake                  payload
//  req         in   req_valid / req_stall      req_t, one tick of input
//  rsp         out  rsp_valid / rsp_stall      rsp_t, line drives and status
//  unit_ticks  in   unit_ticks_we              unit_ticks_data, 16 bits
//
// One transaction per cycle while req_stall is low; a response appears in the cycle
// after its request is taken. The single response register holds the response; the
// sequencer step is combinational logic between the state register and the response register.
// req_stall is high only while a response is held and rsp_stall is high.
// Reset clears the sequencer, empties the response register, unit length 250.
module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        unit_ticks_we,
    input  logic [15:0] unit_ticks_data
);

    seq_state_t  state_reg;
    seq_state_t  state_next;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic        rsp_valid_reg;
    logic [15:0] unit_ticks_reg;
    logic        req_accept;

    assign req_stall  = rsp_valid_reg && rsp_stall;
    assign req_accept = req_valid && !req_stall;

    i2cm_step u_step
    (
        .cur        (state_reg),
        .req        (req),
        .unit_ticks (unit_ticks_reg),
        .nxt        (state_next),
        .rsp        (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end
        else
        begin
            if (unit_ticks_we)
                unit_ticks_reg <= unit_ticks_data;
            if (req_accept)
            begin
                state_reg     <= state_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.busy |-> (state_reg.unit_index == 6'd0 && state_reg.tick_count == 16'd0))
        else $error("idle sequencer holds a non-zero unit or tick count");

    a_unit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.busy |-> (state_reg.unit_index < op_units(state_reg.active_op)))
        else $error("unit index beyond the operation length");

    a_no_accept_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !req_accept)
        else $error("request taken while the response register is held");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.done_res) |-> !rsp_reg.busy_res)
        else $error("done reported while still busy");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req_accept |=> $stable(state_reg))
        else $error("sequencer advanced without a transaction");
`endif

endmodule

### rtl/i2cm_step.sv
// i2cm_step: one tick of the bit timing sequencer, purely combinational.
// Takes current state, request and unit length; gives next state and response.
// Depends on i2cm_pkg.
module i2cm_step
    import i2cm_pkg::*;
(
    input  seq_state_t  cur,
    input  req_t        req,
    input  logic [15:0] unit_ticks,
    output seq_state_t  nxt,
    output rsp_t        rsp
);

    logic       do_act;
    logic [5:0] u;
    logic [5:0] idx;
    logic [8:0] prod;
    logic [2:0] b;
    logic [4:0] rem;
    logic [1:0] ph;
    logic       done;
    logic       rej;

    always_comb
    begin
        nxt    = cur;
        do_act = 1'b0;
        u      = 6'd0;
        done   = 1'b0;
        rej    = 1'b0;
        idx    = cur.unit_index + 6'd1;

        if (cur.busy)
        begin
            rej = req.cmd_valid;
            if (({1'b0, cur.tick_count} + 17'd1) >= {1'b0, unit_ticks})
            begin
                nxt.tick_count = 16'd0;
                if (idx >= op_units(cur.active_op))
                begin
                    nxt.busy       = 1'b0;
                    nxt.unit_index = 6'd0;
                    done           = 1'b1;
                    if (cur.active_op == OP_READ)
                        nxt.rx_byte = cur.shift_byte;
                end
                else
                begin
                    nxt.unit_index = idx;
                    do_act         = 1'b1;
                    u              = idx;
                end
            end
            else
            begin
                nxt.tick_count = cur.tick_count + 16'd1;
            end
        end
        else if (req.cmd_valid)
        begin
            nxt.active_op  = req.opcode;
            nxt.busy       = 1'b1;
            nxt.unit_index = 6'd0;
            nxt.tick_count = 16'd0;
            nxt.ack_choice = req.send_ack;
            nxt.shift_byte = (req.opcode == OP_WRITE) ? req.tx_byte : 8'd0;
            do_act         = 1'b1;
            u              = 6'd0;
        end

        // read bit slots: divide by three through a multiply by 11/32
        prod = {4'd0, u[4:0]} * 9'd11;
        b    = prod[7:5];
        rem  = u[4:0] - (({2'b00, b} << 1) + {2'b00, b});
        ph   = rem[1:0];

        if (do_act)
        begin
            case (nxt.active_op)
                OP_START:
                begin
                    if (u == 6'd0)
                    begin
                        nxt.sda_drive = 1'b0;
                        nxt.scl_drive = 1'b0;
                    end
                    else if (u == 6'd1)
                        nxt.sda_drive = 1'b1;
                    else if (u == 6'd2)
                        nxt.scl_drive = 1'b1;
                end
                OP_STOP:
                begin
                    if (u == 6'd0)
                    begin
                        nxt.scl_drive = 1'b1;
                        nxt.sda_drive = 1'b1;
                    end
                    else if (u == 6'd1)
                        nxt.scl_drive = 1'b0;
                    else if (u == 6'd2)
                        nxt.sda_drive = 1'b0;
                end
                OP_WRITE:
                begin
                    if (u < WRITE_BIT_UNITS)
                    begin
                        case (u[1:0])
                            2'd0:    nxt.scl_drive = 1'b1;
                            2'd1:    nxt.sda_drive = ~nxt.shift_byte[3'd7 - u[4:2]];
                            2'd2:    nxt.scl_drive = 1'b0;
                            default: ;
                        endcase
                    end
                    else if (u == WRITE_BIT_UNITS)
                    begin
                        nxt.scl_drive = 1'b1;
                        nxt.sda_drive = 1'b0;
                    end
                    else if (u == WRITE_ACK_FALL)
                        nxt.scl_drive = 1'b0;
                    else if (u == WRITE_ACK_SAMPLE)
                    begin
                        nxt.nack      = req.sda_in;
                        nxt.scl_drive = 1'b1;
                    end
                end
                default:
                begin
                    if (u < READ_BIT_UNITS)
                    begin
                        if (ph == 2'd0)
                        begin
                            nxt.scl_drive = 1'b1;
                            if (b == 3'd0)
                                nxt.sda_drive = 1'b0;
                        end
                        else if (ph == 2'd1)
                            nxt.scl_drive = 1'b0;
                        else
                            nxt.shift_byte[3'd7 - b] = nxt.shift_byte[3'd7 - b] | req.sda_in;
                    end
                    else if (u == READ_BIT_UNITS)
                    begin
                        nxt.scl_drive = 1'b1;
                        nxt.sda_drive = nxt.ack_choice;
                    end
                    else if (u == READ_ACK_FALL)
                        nxt.scl_drive = 1'b0;
                    else if (u == READ_ACK_END)
                        nxt.scl_drive = 1'b1;
                end
            endcase
        end

        rsp.scl_low  = nxt.scl_drive;
        rsp.sda_low  = nxt.sda_drive;
        rsp.busy_res = nxt.busy;
        rsp.done_res = done;
        rsp.rx_byte  = nxt.rx_byte;
        rsp.nack     = nxt.nack;
        rsp.rejected = rej;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for i2c_master_byte_engine, one tick per transaction.
// Carries its own model of the byte engine and drives bursts and stalls.
// Depends on i2cm_pkg and the i2c_master_byte_engine RTL.
module tb_top
    import i2cm_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_TICKS    = 200;
    localparam int NUM_PHASES     = 3;
    localparam int WHOLE          = -1;
    localparam int MAX_REPORTS    = 20;

    typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_t;
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        unit_ticks_we;
    logic [15:0] unit_ticks_data;

    i2c_master_byte_engine i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .unit_ticks_we   (unit_ticks_we),
        .unit_ticks_data (unit_ticks_data)
    );

    // engine model state
    op_t         eng_op;
    logic        eng_busy;
    logic [5:0]  eng_unit;
    logic [15:0] eng_ticks;
    logic [7:0]  eng_shift;
    logic [7:0]  eng_rx;
    logic        eng_nack;
    logic        eng_scl;
    logic        eng_sda;
    logic        eng_ack;
    logic [15:0] eng_unit_len;

    req_t bus_ticks[$];
    rsp_t expected_status[$];

    int       gen_len;
    int       queued_total;
    int       errors;
    int       ticks_sent;
    int       status_seen;
    int       cmds_started;
    int       done_seen;
    int       reject_seen;
    int       idle_cycles;
    bit       req_taken;
    bit       hold_request;
    int       burst_left;
    int       gap_left;
    int       hold_left;
    int       mode_left;
    rx_mode_t rx_mode;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int op_length(input op_t op);
        case (op)
            OP_START: return int'(START_UNITS);
            OP_STOP:  return int'(STOP_UNITS);
            OP_WRITE: return int'(WRITE_UNITS);
            default:  return int'(READ_UNITS);
        endcase
    endfunction

    // line actions at the start of unit u
    task automatic unit_actions(input op_t op, input logic [5:0] u, input logic sda);
        int         b;
        logic [1:0] ph;
        case (op)
            OP_START:
            begin
                if (u == 6'd0)
                begin
                    eng_sda = 1'b0;
                    eng_scl = 1'b0;
                end
                else if (u == 6'd1)
                    eng_sda = 1'b1;
                else if (u == 6'd2)
                    eng_scl = 1'b1;
            end
            OP_STOP:
            begin
                if (u == 6'd0)
                begin
                    eng_scl = 1'b1;
                    eng_sda = 1'b1;
                end
                else if (u == 6'd1)
                    eng_scl = 1'b0;
                else if (u == 6'd2)
                    eng_sda = 1'b0;
            end
            OP_WRITE:
            begin
                if (u < WRITE_BIT_UNITS)
                begin
                    b  = int'(u >> 2);
                    ph = u[1:0];
                    if (ph == 2'd0)
                        eng_scl = 1'b1;
                    else if (ph == 2'd1)
                        eng_sda = ~eng_shift[7 - b];
                    else if (ph == 2'd2)
                        eng_scl = 1'b0;
                end
                else if (u == WRITE_BIT_UNITS)
                begin
                    eng_scl = 1'b1;
                    eng_sda = 1'b0;
                end
                else if (u == WRITE_ACK_FALL)
                    eng_scl = 1'b0;
                else if (u == WRITE_ACK_SAMPLE)
                begin
                    eng_nack = sda;
                    eng_scl  = 1'b1;
                end
            end
            default:
            begin
                if (u < READ_BIT_UNITS)
                begin
                    b  = int'(u) / 3;
                    ph = 2'(int'(u) % 3);
                    if (ph == 2'd0)
                    begin
                        eng_scl = 1'b1;
                        if (b == 0)
                            eng_sda = 1'b0;
                    end
                    else if (ph == 2'd1)
                        eng_scl = 1'b0;
                    else
                        eng_shift[7 - b] = eng_shift[7 - b] | sda;
                end
                else if (u == READ_BIT_UNITS)
                begin
                    eng_scl = 1'b1;
                    eng_sda = eng_ack;
                end
                else if (u == READ_ACK_FALL)
                    eng_scl = 1'b0;
                else if (u == READ_ACK_END)
                    eng_scl = 1'b1;
            end
        endcase
    endtask

    // one clock tick of the engine
    task automatic engine_tick(input req_t r, output rsp_t o);
        logic done;
        logic rej;
        done = 1'b0;
        rej  = 1'b0;
        if (eng_busy)
        begin
            if (r.cmd_valid)
                rej = 1'b1;
            if ({1'b0, eng_ticks} + 17'd1 >= {1'b0, eng_unit_len})
            begin
                eng_ticks = '0;
                eng_unit  = eng_unit + 6'd1;
                if (int'(eng_unit) >= op_length(eng_op))
                begin
                    eng_busy = 1'b0;
                    done     = 1'b1;
                    eng_unit = '0;
                    if (eng_op == OP_READ)
                        eng_rx = eng_shift;
                end
                else
                    unit_actions(eng_op, eng_unit, r.sda_in);
            end
            else
                eng_ticks = eng_ticks + 16'd1;
        end
        else if (r.cmd_valid)
        begin
            eng_op    = r.opcode;
            eng_busy  = 1'b1;
            eng_unit  = '0;
            eng_ticks = '0;
            eng_ack   = r.send_ack;
            eng_shift = (r.opcode == OP_WRITE) ? r.tx_byte : 8'h00;
            cmds_started++;
            unit_actions(eng_op, 6'd0, r.sda_in);
        end
        o.scl_low  = eng_scl;
        o.sda_low  = eng_sda;
        o.busy_res = eng_busy;
        o.done_res = done;
        o.rx_byte  = eng_rx;
        o.nack     = eng_nack;
        o.rejected = rej;
    endtask

    function automatic req_t noise_tick(input logic valid);
        req_t t;
        t.cmd_valid = valid;
        t.opcode    = op_t'($urandom_range(0, 3));
        t.tx_byte   = 8'($urandom);
        t.send_ack  = 1'($urandom_range(0, 1));
        t.sda_in    = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic void queue_tick(input req_t t, input sda_mode_t mode);
        if (mode != SDA_RANDOM)
            t.sda_in = (mode == SDA_HIGH);
        bus_ticks.push_back(t);
        queued_total++;
    endfunction

    task automatic add_idle(input int n);
        repeat (n) queue_tick(noise_tick(1'b0), SDA_RANDOM);
    endtask

    // command tick, then ticks up to and including the done tick, or max_fill ticks if fewer
    task automatic add_command(input op_t op, input logic [7:0] txb, input logic ack,
                               input sda_mode_t mode, input bit hit_done, input int max_fill);
        req_t t;
        int   n;
        t          = noise_tick(1'b1);
        t.opcode   = op;
        t.tx_byte  = txb;
        t.send_ack = ack;
        queue_tick(t, mode);
        n = op_length(op) * ((gen_len == 0) ? 1 : gen_len);
        if (max_fill != WHOLE && max_fill < n)
            n = max_fill;
        for (int i = 1; i <= n; i++)
            queue_tick(noise_tick($urandom_range(0, 15) == 0 || (hit_done && i == n)), mode);
        add_idle($urandom_range(0, 2));
    endtask

    task automatic add_transfer();
        bit rd;
        int n;
        if ($urandom_range(0, 7) == 0)
            add_command(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
                        SDA_RANDOM, $urandom_range(0, 5) == 0, WHOLE);
        else
        begin
            rd = 1'($urandom_range(0, 1));
            n  = $urandom_range(1, 3);
            add_command(OP_START, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0, WHOLE);
            add_command(OP_WRITE, {7'($urandom), rd}, 1'b0, SDA_RANDOM,
                        $urandom_range(0, 5) == 0, WHOLE);
            if ($urandom_range(0, 3) == 0)
            begin
                add_command(OP_START, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0, WHOLE);
                add_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0, WHOLE);
            end
            for (int i = 0; i < n; i++)
                add_command(rd ? OP_READ : OP_WRITE, 8'($urandom),
                            (i < n - 1) ? 1'b1 : 1'($urandom_range(0, 1)),
                            SDA_RANDOM, $urandom_range(0, 5) == 0, WHOLE);
            add_command(OP_STOP, 8'($urandom), 1'b0, SDA_RANDOM,
                        $urandom_range(0, 5) == 0, WHOLE);
        end
    endtask

    // checked at the rising edge, where the sender's outputs are settled
    task automatic wait_drained();
        @(posedge clk);
        while (bus_ticks.size() != 0 || req_valid || expected_status.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_unit_len(input logic [15:0] v);
        wait_drained();
        unit_ticks_we   <= 1'b1;
        unit_ticks_data <= v;
        eng_unit_len = v;
        gen_len      = int'(v);
        @(negedge clk);
        unit_ticks_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // sender: bursts of random length with gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (bus_ticks.size() == 0)
                req_valid <= 1'b0;
            else
            begin
                req_valid <= 1'b1;
                req       <= bus_ticks.pop_front();
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 80);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            rsp_stall   <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 300);
            end
            else
                mode_left--;
            case (rx_mode)
                RX_FREE:  rsp_stall <= 1'b0;
                RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                default:  rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // monitor, prediction and progress count
    always @(posedge clk)
    begin : sample
        rsp_t want;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (rsp_valid && !rsp_stall)
            begin
                moved = 1'b1;
                status_seen++;
                if (expected_status.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected nothing actual %p", $time, rsp);
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("scl_low", want.scl_low, rsp.scl_low);
                    check_field("sda_low", want.sda_low, rsp.sda_low);
                    check_field("busy_res", want.busy_res, rsp.busy_res);
                    check_field("done_res", want.done_res, rsp.done_res);
                    check_field("rx_byte", want.rx_byte, rsp.rx_byte);
                    check_field("nack", want.nack, rsp.nack);
                    check_field("rejected", want.rejected, rsp.rejected);
                    if (want.done_res)
                        done_seen++;
                    if (want.rejected)
                        reject_seen++;
                end
            end
            req_taken = req_valid && !req_stall;
            if (req_taken)
            begin
                moved = 1'b1;
                engine_tick(req, want);
                expected_status.push_back(want);
                ticks_sent++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        rsp_stall       = 1'b0;
        unit_ticks_we   = 1'b0;
        unit_ticks_data = '0;
        eng_op          = OP_START;
        eng_busy        = 1'b0;
        eng_unit        = '0;
        eng_ticks       = '0;
        eng_shift       = '0;
        eng_rx          = '0;
        eng_nack        = 1'b0;
        eng_scl         = 1'b0;
        eng_sda         = 1'b0;
        eng_ack         = 1'b0;
        eng_unit_len    = UNIT_TICKS_RESET;
        gen_len         = int'(UNIT_TICKS_RESET);
        burst_left      = 1;
        rx_mode         = RX_FREE;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset unit length
        add_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0, WHOLE);

        // zero unit length acts as one; fixed data and line levels
        set_unit_len(16'd0);
        add_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0, WHOLE);
        add_command(OP_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0, WHOLE);
        add_command(OP_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b1, WHOLE);
        add_command(OP_READ, 8'hFF, 1'b1, SDA_HIGH, 1'b0, WHOLE);
        add_command(OP_READ, 8'h00, 1'b0, SDA_LOW, 1'b1, WHOLE);
        add_command(OP_STOP, 8'hFF, 1'b1, SDA_RANDOM, 1'b0, WHOLE);

        set_unit_len(16'd1);
        add_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1, WHOLE);
        add_command(OP_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 1'b0, WHOLE);
        add_command(OP_READ, 8'hA5, 1'b0, SDA_RANDOM, 1'b0, WHOLE);
        add_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1, WHOLE);

        // longest unit, then cut short while the count is already past the new length
        set_unit_len(16'hFFFF);
        add_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0, 40);
        set_unit_len(16'd4);
        add_idle(12);
        add_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0, WHOLE);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            set_unit_len(16'($urandom_range(1, 4)));
            if (phase == 2)
                hold_request = 1'b1;
            queued_total = 0;
            while (queued_total < PHASE_TICKS)
                add_transfer();
        end

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Covered %0d tick transactions, %0d commands started, %0d completed,",
                 ticks_sent, cmds_started, done_seen);
        $display("%0d rejected while busy; unit lengths 0, 1, 250, 65535 and random small.",
                 reject_seen);
        if (errors == 0 && expected_status.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
